FILE: src/pdlz_pkg.sv
// Package with the types and constants of the PalmDOC LZ77 decoder.
package pdlz_pkg;

  // Sequencer states, one-hot.
  typedef enum logic [3:0] {
    StIdle = 4'b0001,
    StRead = 4'b0010,
    StCap  = 4'b0100,
    StEmit = 4'b1000
  } state_e;

  // Token parse phase, one-hot.
  typedef enum logic [2:0] {
    PhToken = 3'b001,
    PhRaw   = 3'b010,
    PhRef   = 3'b100
  } phase_e;

  // Token byte boundaries and fixed values.
  localparam logic [7:0] LitLow    = 8'h09;
  localparam logic [7:0] LitHigh   = 8'h7F;
  localparam logic [7:0] RawHigh   = 8'h08;
  localparam logic [7:0] RefHigh   = 8'hBF;
  localparam logic [7:0] ByteZero  = 8'h00;
  localparam logic [7:0] ByteSpace = 8'h20;
  localparam logic [7:0] ByteFlip  = 8'h80;
  localparam logic [3:0] LenBias   = 4'd3;

  // Produced count saturates at the reach of an 11-bit distance.
  localparam int unsigned CountW      = 12;
  localparam logic [CountW-1:0] ProducedMax = 12'd2048;
  localparam int unsigned DistW       = 11;

endpackage

FILE: src/pdlz_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module pdlz_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/palmdoc_lz77_decoder.sv
// Top level of the PalmDOC LZ77 decoder: token parser, copy sequencer and history.
// A literal, raw, bypass or space-pair word registers its first result byte,
// offered in the next cycle; token heads produce none. Each back-reference byte
// passes through history read, capture and offer. A new input word is accepted
// only in idle, once every byte of the last has been taken; bytes are paced by
// the single output register shared by every byte and the one history read port.
// Reset clears the parser, pointers and bypass; history content stays undefined.
module palmdoc_lz77_decoder #(
  parameter int unsigned HISTORY_DEPTH = 2048
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       record_start_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       last_of_run_o,
  output logic       bad_distance_o
);

  import pdlz_pkg::*;

  localparam int unsigned AW = $clog2(HISTORY_DEPTH);
  localparam logic [AW-1:0] WpLast = AW'(HISTORY_DEPTH - 1);
  localparam logic [AW:0]   DepthW = (AW+1)'(HISTORY_DEPTH);

  state_e state_q, state_d;
  phase_e phase_q, phase_d;
  logic [AW-1:0]     wp_q, wp_d;
  logic [CountW-1:0] cnt_q, cnt_d;
  logic [3:0]        raw_q, raw_d;
  logic [5:0]        held_q, held_d;
  logic              bypass_q;
  logic [DistW-1:0]  dist_q, dist_d;
  logic [3:0]        left_q, left_d;
  logic [7:0]        pend_q, pend_d;
  logic              pend_v_q, pend_v_d;
  logic [7:0]        out_byte_q, out_byte_d;
  logic              last_q, last_d;
  logic              bad_q, bad_d;

  logic              ram_we;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;
  logic [AW-1:0]     ram_raddr;
  logic [AW:0]       rd_sum;

  logic              in_acc;
  logic              clr;
  logic [AW-1:0]     wp_base, wp_inc;
  logic [CountW-1:0] cnt_base, cnt_inc;
  phase_e            phase_base;
  logic [3:0]        raw_base, raw_dec;
  logic [5:0]        held_base;
  logic [13:0]       ld;
  logic [DistW-1:0]  ld_dist;
  logic [3:0]        ld_len;
  logic [7:0]        b;

  assign in_ready_o     = (state_q == StIdle);
  assign out_valid_o    = (state_q == StEmit);
  assign out_byte_o     = out_byte_q;
  assign last_of_run_o  = last_q;
  assign bad_distance_o = bad_q;

  assign in_acc = in_valid_i && in_ready_o;
  assign clr    = in_acc && record_start_i;
  assign b      = data_byte_i;

  // Parse state as seen by the word, after a record start has cleared it.
  assign wp_base    = clr ? '0 : wp_q;
  assign cnt_base   = clr ? '0 : cnt_q;
  assign phase_base = clr ? PhToken : phase_q;
  assign raw_base   = clr ? '0 : raw_q;
  assign held_base  = clr ? '0 : held_q;
  assign raw_dec    = (raw_base != 4'd0) ? raw_base - 4'd1 : 4'd0;

  // Shared pointer unit: advance the write pointer and the produced count.
  assign wp_inc  = (wp_base == WpLast) ? '0 : wp_base + AW'(1);
  assign cnt_inc = (cnt_base < ProducedMax) ? cnt_base + CountW'(1) : cnt_base;

  // Second reference byte split into distance and length.
  assign ld      = {held_base, b};
  assign ld_dist = ld[13:3];
  assign ld_len  = {1'b0, ld[2:0]} + LenBias;

  // Copy source address, wrapped into the history.
  assign rd_sum    = {1'b0, wp_q} + DepthW - (AW+1)'(dist_q);
  assign ram_raddr = (rd_sum >= DepthW) ? AW'(rd_sum - DepthW) : rd_sum[AW-1:0];

  // Sequencer and token parser.
  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    wp_d       = wp_q;
    cnt_d      = cnt_q;
    raw_d      = raw_q;
    held_d     = held_q;
    dist_d     = dist_q;
    left_d     = left_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    out_byte_d = out_byte_q;
    last_d     = last_q;
    bad_d      = bad_q;
    ram_we     = 1'b0;
    ram_wdata  = b;

    case (state_q)
      StIdle: begin
        if (in_acc) begin
          wp_d    = wp_base;
          cnt_d   = cnt_base;
          phase_d = phase_base;
          raw_d   = raw_base;
          held_d  = held_base;
          last_d  = 1'b1;
          bad_d   = 1'b0;
          if (bypass_q) begin
            out_byte_d = b;
            state_d    = StEmit;
          end else begin
            case (phase_base)
              PhRaw: begin
                ram_we     = 1'b1;
                wp_d       = wp_inc;
                cnt_d      = cnt_inc;
                out_byte_d = b;
                raw_d      = raw_dec;
                phase_d    = (raw_dec == 4'd0) ? PhToken : PhRaw;
                state_d    = StEmit;
              end
              PhRef: begin
                phase_d = PhToken;
                held_d  = '0;
                if (ld_dist == '0 || CountW'(ld_dist) > cnt_base) begin
                  out_byte_d = ByteZero;
                  bad_d      = 1'b1;
                  state_d    = StEmit;
                end else begin
                  dist_d  = ld_dist;
                  left_d  = ld_len;
                  state_d = StRead;
                end
              end
              default: begin
                if (b inside {ByteZero, [LitLow:LitHigh]}) begin
                  ram_we     = 1'b1;
                  wp_d       = wp_inc;
                  cnt_d      = cnt_inc;
                  out_byte_d = b;
                  state_d    = StEmit;
                end else if (b <= RawHigh) begin
                  raw_d   = b[3:0];
                  phase_d = PhRaw;
                end else if (b <= RefHigh) begin
                  held_d  = b[5:0];
                  phase_d = PhRef;
                end else begin
                  ram_we     = 1'b1;
                  ram_wdata  = ByteSpace;
                  wp_d       = wp_inc;
                  cnt_d      = cnt_inc;
                  out_byte_d = ByteSpace;
                  last_d     = 1'b0;
                  pend_d     = b ^ ByteFlip;
                  pend_v_d   = 1'b1;
                  state_d    = StEmit;
                end
              end
            endcase
          end
        end
      end
      StRead: begin
        state_d = StCap;
      end
      StCap: begin
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        wp_d       = wp_inc;
        cnt_d      = cnt_inc;
        out_byte_d = ram_rdata;
        last_d     = (left_q == 4'd1);
        bad_d      = 1'b0;
        left_d     = left_q - 4'd1;
        state_d    = StEmit;
      end
      StEmit: begin
        if (out_ready_i) begin
          if (pend_v_q) begin
            ram_we     = 1'b1;
            ram_wdata  = pend_q;
            wp_d       = wp_inc;
            cnt_d      = cnt_inc;
            out_byte_d = pend_q;
            last_d     = 1'b1;
            pend_v_d   = 1'b0;
          end else if (left_q != 4'd0) begin
            state_d = StRead;
          end else begin
            state_d = StIdle;
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= StIdle;
      phase_q  <= PhToken;
      wp_q     <= '0;
      cnt_q    <= '0;
      raw_q    <= '0;
      held_q   <= '0;
      left_q   <= '0;
      pend_v_q <= 1'b0;
      bypass_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      phase_q  <= phase_d;
      wp_q     <= wp_d;
      cnt_q    <= cnt_d;
      raw_q    <= raw_d;
      held_q   <= held_d;
      left_q   <= left_d;
      pend_v_q <= pend_v_d;
      if (cfg_we_i) begin
        bypass_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    dist_q     <= dist_d;
    pend_q     <= pend_d;
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
    bad_q      <= bad_d;
  end

  // History of produced bytes.
  pdlz_ram #(
    .Width(8),
    .Depth(HISTORY_DEPTH)
  ) u_history (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(wp_base),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

endmodule
